// ----- rtl/lsh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the level-of-detail selector.
// Used by lod_select_hysteresis; depends on nothing else.
package lsh_pkg;

    // Number of detail levels the hardware holds thresholds for.
    localparam int LEVELS = 4;

    // Squared distance (Q32.32) below which the object counts as touching the camera.
    localparam logic [65:0] NEAR_SQ = 66'd4295;
    // 1.0 in Q1.16.
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Sequencer step counts.
    localparam int SQ_STEPS   = 4;   // three squares plus the cull radius squared
    localparam int SQRT_STEPS = 33;  // one bit per step of the 33-bit root
    localparam int DIV_STEPS  = 16;  // one fraction bit per step

    // Datapath widths.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int UNIT_W = 54;

    typedef enum logic [2:0] {
        CFG_LEVEL_COUNT = 3'd0,
        CFG_CULL_DIST   = 3'd1,
        CFG_HALF_FOV    = 3'd2,
        CFG_HYST_BAND   = 3'd3,
        CFG_THR0        = 3'd4,
        CFG_THR1        = 3'd5,
        CFG_THR2        = 3'd6,
        CFG_THR3        = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_SQRT,
        ST_SCALE,
        ST_FRAC,
        ST_DIV,
        ST_SELECT,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/lod_select_hysteresis.sv -----
`timescale 1ns / 1ps
// Level-of-detail selector with hysteresis: top level and its whole datapath.
// Depends on lsh_pkg for the state type, register indexes and constants.
//
// Usage. A query word on the s_ channel carries camera and object positions
// and a bounding radius. The block finds the camera-to-object distance, the
// share of the screen height that the bounding sphere covers, and picks the
// first detail level whose threshold that share meets, or else the last one;
// thresholds of levels before the previously chosen one are raised by the
// hysteresis band and those after it lowered. A near object gets level zero
// and a culled one no level. One result word per query leaves on the m_
// channel. Configuration is to be written through cfg_we/cfg_index/cfg_wdata
// only while no query is in flight; the block itself does not enforce this.
// Timing. The block holds one query at a time and is not ready while it works.
// The result word comes early when no levels are set up, at the near or cull
// check, and when the sphere fills the screen, which skips the division; the
// next query is taken once the word is in the output register. The longest
// steps are the square root, one bit per cycle on the shared compare-subtract
// unit, and the fraction division on the same unit; a single 33x33 multiplier
// does the squares, the cull radius square and the distance scaling.
// Reset clears the configuration to its defaults and the remembered level to
// zero. When the receiver stalls, the result word is held in the output
// register; the block still accepts the next query, and only holds that
// query's result back until the previous word has been taken.
module lod_select_hysteresis (
    input  logic         aclk,
    input  logic         aresetn,
    // Query channel. s_tdata from bit 0 up: cam_x, cam_y, cam_z, obj_x, obj_y,
    // obj_z (signed Q16.16), bounding_radius (unsigned Q16.16), 32 bits each.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,
    // Result channel. m_tdata from bit 0 up: level_valid (1), level_index (2),
    // five zero bits.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    // Configuration registers.
    logic [2:0]  level_count_reg;
    logic [31:0] cull_dist_reg;
    logic [19:0] half_fov_reg;
    logic [15:0] hyst_band_reg;
    logic [16:0] thr_reg [lsh_pkg::LEVELS];

    // Sequencer and datapath state.
    lsh_pkg::state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [1:0]  last_level_reg;
    logic [2:0]  n_reg;
    logic [31:0] mag_reg [3];
    logic [31:0] radius_reg;
    logic [lsh_pkg::PROD_W-1:0] sum_reg;
    logic [lsh_pkg::PROD_W-1:0] prod_reg;
    logic [lsh_pkg::UNIT_W-1:0] rem_reg;
    logic [32:0] root_reg;
    logic [16:0] frac_reg;
    logic        res_valid_reg;
    logic [1:0]  res_idx_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic        out_valid_reg;
    logic [1:0]  out_idx_reg;

    // Combinational datapath signals.
    logic [lsh_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [lsh_pkg::PROD_W-1:0] mul_p;
    logic [lsh_pkg::UNIT_W-1:0] unit_a, unit_b;
    logic [lsh_pkg::UNIT_W:0]   unit_diff;
    logic        unit_ge;
    logic        near_hit, cull_hit, out_free, accept;
    logic [1:0]  sel_idx;
    logic [32:0] d_x, d_y, d_z;
    logic [31:0] m_x, m_y, m_z;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_idx_reg, out_valid_reg};

    // Axis differences and their magnitudes, taken when the query is accepted.
    assign d_x = {s_tdata[127], s_tdata[127:96]}  - {s_tdata[31], s_tdata[31:0]};
    assign d_y = {s_tdata[159], s_tdata[159:128]} - {s_tdata[63], s_tdata[63:32]};
    assign d_z = {s_tdata[191], s_tdata[191:160]} - {s_tdata[95], s_tdata[95:64]};
    assign m_x = d_x[32] ? 32'(-d_x) : d_x[31:0];
    assign m_y = d_y[32] ? 32'(-d_y) : d_y[31:0];
    assign m_z = d_z[32] ? 32'(-d_z) : d_z[31:0];

    // Shared multiplier and shared compare-subtract unit.
    assign mul_p     = mul_a * mul_b;
    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge   = !unit_diff[lsh_pkg::UNIT_W];

    // The near check and the cull check look at the finished squared distance;
    // prod_reg holds the cull distance squared at that point.
    assign near_hit = sum_reg < lsh_pkg::NEAR_SQ;
    assign cull_hit = (cull_dist_reg != 32'd0) && (sum_reg > {2'b0, prod_reg[63:0]});

    // Threshold search over the configured levels: first match, else the last.
    always_comb begin
        logic signed [18:0] thr_v;
        logic               found;
        sel_idx = 2'(n_reg - 3'd1);
        found   = 1'b0;
        thr_v   = '0;
        for (int i = 0; i < lsh_pkg::LEVELS; i++) begin
            if (!found && (3'(i) < n_reg)) begin
                thr_v = $signed({2'b0, thr_reg[i]});
                if (2'(i) > last_level_reg) begin
                    thr_v = thr_v - $signed({3'b0, hyst_band_reg});
                end else if (2'(i) < last_level_reg) begin
                    thr_v = thr_v + $signed({3'b0, hyst_band_reg});
                end
                if ($signed({2'b0, frac_reg}) >= thr_v) begin
                    sel_idx = 2'(i);
                    found   = 1'b1;
                end
            end
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsh_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (level_count_reg == 3'd0) ? lsh_pkg::ST_DONE
                                                           : lsh_pkg::ST_SQUARE;
                end
            end
            lsh_pkg::ST_SQUARE: begin
                if (cnt_reg == 6'(lsh_pkg::SQ_STEPS - 1)) begin
                    state_next = lsh_pkg::ST_CHECK;
                end
            end
            lsh_pkg::ST_CHECK: begin
                state_next = (near_hit || cull_hit) ? lsh_pkg::ST_DONE : lsh_pkg::ST_SQRT;
            end
            lsh_pkg::ST_SQRT: begin
                if (cnt_reg == 6'(lsh_pkg::SQRT_STEPS - 1)) begin
                    state_next = lsh_pkg::ST_SCALE;
                end
            end
            lsh_pkg::ST_SCALE: begin
                state_next = lsh_pkg::ST_FRAC;
            end
            lsh_pkg::ST_FRAC: begin
                state_next = unit_ge ? lsh_pkg::ST_SELECT : lsh_pkg::ST_DIV;
            end
            lsh_pkg::ST_DIV: begin
                if (cnt_reg == 6'(lsh_pkg::DIV_STEPS - 1)) begin
                    state_next = lsh_pkg::ST_SELECT;
                end
            end
            lsh_pkg::ST_SELECT: begin
                state_next = lsh_pkg::ST_DONE;
            end
            lsh_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lsh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsh_pkg::ST_IDLE;
            end
        endcase
    end

    // Per-state controls: handshake and the operands of the shared units.
    always_comb begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unit_a   = '0;
        unit_b   = '0;
        unique case (state_reg)
            lsh_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lsh_pkg::ST_SQUARE: begin
                unique case (cnt_reg[1:0])
                    2'd0:    mul_a = {1'b0, mag_reg[0]};
                    2'd1:    mul_a = {1'b0, mag_reg[1]};
                    2'd2:    mul_a = {1'b0, mag_reg[2]};
                    default: mul_a = {1'b0, cull_dist_reg};
                endcase
                mul_b = mul_a;
            end
            lsh_pkg::ST_SQRT: begin
                // Bring down the next bit pair and try (root << 2) | 1.
                unit_a = {rem_reg[lsh_pkg::UNIT_W-3:0], sum_reg[65:64]};
                unit_b = {19'b0, root_reg, 2'b01};
            end
            lsh_pkg::ST_SCALE: begin
                mul_a = root_reg;
                mul_b = {13'b0, half_fov_reg};
            end
            lsh_pkg::ST_FRAC: begin
                unit_a = {6'b0, radius_reg, 16'b0};
                unit_b = {1'b0, prod_reg[52:0]};
            end
            lsh_pkg::ST_DIV: begin
                unit_a = {rem_reg[lsh_pkg::UNIT_W-2:0], 1'b0};
                unit_b = {1'b0, prod_reg[52:0]};
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lsh_pkg::ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            last_level_reg  <= 2'd0;
            level_count_reg <= 3'd0;
            cull_dist_reg   <= 32'd0;
            half_fov_reg    <= 20'd65536;
            hyst_band_reg   <= 16'd1311;
            for (int i = 0; i < lsh_pkg::LEVELS; i++) begin
                thr_reg[i] <= 17'd0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == lsh_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (res_valid_reg) begin
                    last_level_reg <= res_idx_reg;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (lsh_pkg::cfg_idx_t'(cfg_index))
                    lsh_pkg::CFG_LEVEL_COUNT: level_count_reg <= cfg_wdata[2:0];
                    lsh_pkg::CFG_CULL_DIST:   cull_dist_reg   <= cfg_wdata;
                    lsh_pkg::CFG_HALF_FOV:    half_fov_reg    <= cfg_wdata[19:0];
                    lsh_pkg::CFG_HYST_BAND:   hyst_band_reg   <= cfg_wdata[15:0];
                    lsh_pkg::CFG_THR0:        thr_reg[0]      <= cfg_wdata[16:0];
                    lsh_pkg::CFG_THR1:        thr_reg[1]      <= cfg_wdata[16:0];
                    lsh_pkg::CFG_THR2:        thr_reg[2]      <= cfg_wdata[16:0];
                    lsh_pkg::CFG_THR3:        thr_reg[3]      <= cfg_wdata[16:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == lsh_pkg::ST_DONE && out_free) begin
            out_valid_reg <= res_valid_reg;
            out_idx_reg   <= res_idx_reg;
        end
        unique case (state_reg)
            lsh_pkg::ST_IDLE: begin
                if (accept) begin
                    mag_reg[0]    <= m_x;
                    mag_reg[1]    <= m_y;
                    mag_reg[2]    <= m_z;
                    radius_reg    <= s_tdata[223:192];
                    n_reg         <= (level_count_reg > 3'(lsh_pkg::LEVELS))
                                     ? 3'(lsh_pkg::LEVELS) : level_count_reg;
                    sum_reg       <= '0;
                    cnt_reg       <= 6'd0;
                    res_valid_reg <= 1'b0;
                    res_idx_reg   <= 2'd0;
                end
            end
            lsh_pkg::ST_SQUARE: begin
                prod_reg <= mul_p;
                if (cnt_reg != 6'd0) begin
                    sum_reg <= sum_reg + prod_reg;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            lsh_pkg::ST_CHECK: begin
                if (near_hit) begin
                    res_valid_reg <= 1'b1;
                    res_idx_reg   <= 2'd0;
                end
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'd0;
            end
            lsh_pkg::ST_SQRT: begin
                rem_reg  <= unit_ge ? unit_diff[lsh_pkg::UNIT_W-1:0] : unit_a;
                root_reg <= {root_reg[31:0], unit_ge};
                sum_reg  <= {sum_reg[lsh_pkg::PROD_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            lsh_pkg::ST_SCALE: begin
                prod_reg <= mul_p;
            end
            lsh_pkg::ST_FRAC: begin
                // Radius at or beyond distance times tangent fills the screen.
                frac_reg <= unit_ge ? lsh_pkg::ONE_Q16 : 17'd0;
                rem_reg  <= unit_a;
                cnt_reg  <= 6'd0;
            end
            lsh_pkg::ST_DIV: begin
                rem_reg  <= unit_ge ? unit_diff[lsh_pkg::UNIT_W-1:0] : unit_a;
                frac_reg <= {frac_reg[15:0], unit_ge};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            lsh_pkg::ST_SELECT: begin
                res_valid_reg <= 1'b1;
                res_idx_reg   <= sel_idx;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // An accepted query always starts the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != lsh_pkg::ST_IDLE)
        else $error("sequencer did not leave idle after a query");

    // The root never runs past its final bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lsh_pkg::ST_SQRT |-> cnt_reg < 6'(lsh_pkg::SQRT_STEPS))
        else $error("square root step count overran");

    // The screen fraction stays within 0..1 when the levels are searched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lsh_pkg::ST_SELECT |-> frac_reg <= lsh_pkg::ONE_Q16)
        else $error("screen fraction above one");

    // A delivered level is the one remembered for the next query.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_valid_reg |-> last_level_reg == out_idx_reg)
        else $error("remembered level differs from the delivered level");

    // An invalid result carries level zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !out_valid_reg |-> out_idx_reg == 2'd0)
        else $error("invalid result with a nonzero level");
`endif

endmodule

// ----- dv/tb_lod_select_hysteresis.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lod_select_hysteresis: directed queries, then random phases.
// Depends on lsh_pkg for the register indexes and on the RTL of the block alone.
module tb_lod_select_hysteresis;

    // One query word as it travels on s_tdata; the last member sits in the lowest bits.
    typedef struct packed {
        logic [31:0]        radius;
        logic signed [31:0] obj_z;
        logic signed [31:0] obj_y;
        logic signed [31:0] obj_x;
        logic signed [31:0] cam_z;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_x;
    } query_t;

    localparam int          SLOT_COUNT  = 4;          // thresholds the block holds
    localparam logic [65:0] TOUCH_SQ    = 66'd4295;   // distance under 0.001, squared
    localparam logic [16:0] FULL_SCREEN = 17'd65536;  // 1.0 in Q1.16
    localparam int          REPORT_CAP  = 60;
    localparam int          CYCLE_LIMIT = 1500000;

    // Tracks the configuration and the remembered level, and keeps the expected result
    // words in query order.
    class lod_level_predictor;
        logic [2:0]  level_count;
        logic [31:0] cull_dist;
        logic [19:0] half_fov_tan;
        logic [15:0] band;
        logic [16:0] thr [SLOT_COUNT];
        logic [1:0]  last_level;
        logic [2:0]  expected_levels [$];   // {level_index, level_valid}
        int unsigned mismatches;

        function new();
            level_count  = 3'd0;
            cull_dist    = 32'd0;
            half_fov_tan = 20'd65536;
            band         = 16'd1311;
            foreach (thr[i]) thr[i] = 17'd0;
            last_level   = 2'd0;
            mismatches   = 0;
        endfunction

        function void write_reg(lsh_pkg::cfg_idx_t idx, logic [31:0] val);
            case (idx)
                lsh_pkg::CFG_LEVEL_COUNT: level_count  = val[2:0];
                lsh_pkg::CFG_CULL_DIST:   cull_dist    = val;
                lsh_pkg::CFG_HALF_FOV:    half_fov_tan = val[19:0];
                lsh_pkg::CFG_HYST_BAND:   band         = val[15:0];
                lsh_pkg::CFG_THR0:        thr[0]       = val[16:0];
                lsh_pkg::CFG_THR1:        thr[1]       = val[16:0];
                lsh_pkg::CFG_THR2:        thr[2]       = val[16:0];
                lsh_pkg::CFG_THR3:        thr[3]       = val[16:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        // Appends one expected result word behind the ones already waiting.
        function void queue_word(logic [2:0] w);
            expected_levels = {expected_levels, w};
        endfunction

        function logic [65:0] axis_sq(logic signed [31:0] a, logic signed [31:0] b);
            longint      gap;
            logic [65:0] mag;
            gap = longint'(b) - longint'(a);
            mag = (gap < 0) ? -gap : gap;
            return mag * mag;
        endfunction

        // Digit-by-digit square root, two radicand bits per step, rounded down.
        function logic [32:0] root66(logic [65:0] v);
            logic [39:0] acc, rem, trial;
            acc = 40'd0;
            rem = 40'd0;
            for (int k = 32; k >= 0; k--) begin
                rem   = (rem << 2) | {38'd0, v[2*k +: 2]};
                trial = (acc << 2) | 40'd1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    acc = (acc << 1) | 40'd1;
                end else begin
                    acc = acc << 1;
                end
            end
            return acc[32:0];
        endfunction

        function void note_query(query_t q);
            int unsigned n;
            logic [65:0] dist_sq, cull_sq, cull_wide;
            logic [32:0] distance;
            logic [63:0] scaled, num, rem;
            logic [16:0] frac;
            logic [1:0]  pick;
            longint      bar;
            bit          found;
            n = (level_count > SLOT_COUNT) ? SLOT_COUNT : level_count;
            if (n == 0) begin
                queue_word(3'b000);
                return;
            end
            dist_sq = axis_sq(q.cam_x, q.obj_x) + axis_sq(q.cam_y, q.obj_y)
                    + axis_sq(q.cam_z, q.obj_z);
            if (dist_sq < TOUCH_SQ) begin
                last_level = 2'd0;
                queue_word(3'b001);
                return;
            end
            cull_wide = {34'd0, cull_dist};
            cull_sq   = cull_wide * cull_wide;
            if (cull_dist != 32'd0 && dist_sq > cull_sq) begin
                queue_word(3'b000);
                return;
            end
            distance = root66(dist_sq);
            scaled   = {31'd0, distance} * {44'd0, half_fov_tan};
            num      = {16'd0, q.radius, 16'd0};
            if (num >= scaled) begin
                frac = FULL_SCREEN;
            end else begin
                rem  = num;
                frac = 17'd0;
                for (int b = 0; b < 16; b++) begin
                    rem  = rem << 1;
                    frac = frac << 1;
                    if (rem >= scaled) begin
                        rem     = rem - scaled;
                        frac[0] = 1'b1;
                    end
                end
            end
            // Levels better than the remembered one need more screen, worse ones less.
            // A remembered level past the active count makes every level a better one.
            pick  = 2'(n - 1);
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                bar = longint'(thr[i]);
                if (i > last_level)
                    bar = bar - longint'(band);
                else if (i < last_level)
                    bar = bar + longint'(band);
                if (!found && longint'(frac) >= bar) begin
                    pick  = 2'(i);
                    found = 1'b1;
                end
            end
            last_level = pick;
            queue_word({pick, 1'b1});
        endfunction

        function void flag(string field, int want, int got);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_word(logic [7:0] w);
            logic [2:0] want;
            if (expected_levels.size() == 0) begin
                flag("unexpected result word, level_valid", -1, w[0]);
                return;
            end
            want = expected_levels.pop_front();
            if (w[0] !== want[0])
                flag("level_valid", want[0], w[0]);
            if (w[2:1] !== want[2:1])
                flag("level_index", want[2:1], w[2:1]);
        endfunction
    endclass

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata   = '0;   // cam_x, cam_y, cam_z, obj_x, obj_y, obj_z, radius
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [7:0]   m_tdata;          // level_valid, level_index, five zero bits
    logic         cfg_we    = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    lod_level_predictor levels;
    int unsigned        cycle_count = 0;
    int                 burst_left  = 0;

    // State of the current random trajectory: an object at a fixed offset whose
    // radius wanders, so the screen share drifts back and forth over the thresholds.
    query_t traj_q;
    int     traj_left = 0;
    real    traj_step;

    lod_select_hysteresis dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Every accepted result word is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1)
            levels.check_word(m_tdata);
    end

    // A run that hangs ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lod_select_hysteresis verification failed");
            $finish;
        end
    end

    // The receiver switches between stretches of always-ready, coin-flip readiness
    // and mostly-stalled behavior, each lasting a random number of cycles.
    initial begin : receiver_pattern
        int mode;
        int mode_left;
        forever begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(40, 300);
            while (mode_left > 0) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
                mode_left--;
            end
        end
    end

    // Presents one query word and returns at the falling edge after it was taken.
    // The sender works in bursts; between bursts valid drops for a random gap.
    task automatic send_query(input query_t q);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        levels.note_query(q);
        burst_left--;
        @(negedge aclk);
    endtask

    // Query with the camera at a fixed spot and the object at the given offset.
    task automatic send_offset(input int dx, input int dy, input int dz,
                               input logic [31:0] radius);
        query_t q;
        q.cam_x  = 32'sd229376;     // 3.5
        q.cam_y  = -32'sd131072;    // -2.0
        q.cam_z  = 32'sd6569984;    // 100.25
        q.obj_x  = q.cam_x + dx;
        q.obj_y  = q.cam_y + dy;
        q.obj_z  = q.cam_z + dz;
        q.radius = radius;
        send_query(q);
    endtask

    // Drops valid and waits until every expected word has come back. Each query
    // gives one word, so the block is idle then; an extra wait follows anyway.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (levels.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // One register write per cycle; the caller lowers cfg_we after the last one.
    task automatic program_reg(input lsh_pkg::cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        levels.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic program_all(input logic [2:0] count_v, input logic [31:0] cull_v,
                               input logic [19:0] tan_v, input logic [15:0] band_v,
                               input logic [16:0] t0, input logic [16:0] t1,
                               input logic [16:0] t2, input logic [16:0] t3);
        program_reg(lsh_pkg::CFG_LEVEL_COUNT, {29'd0, count_v});
        program_reg(lsh_pkg::CFG_CULL_DIST, cull_v);
        program_reg(lsh_pkg::CFG_HALF_FOV, {12'd0, tan_v});
        program_reg(lsh_pkg::CFG_HYST_BAND, {16'd0, band_v});
        program_reg(lsh_pkg::CFG_THR0, {15'd0, t0});
        program_reg(lsh_pkg::CFG_THR1, {15'd0, t1});
        program_reg(lsh_pkg::CFG_THR2, {15'd0, t2});
        program_reg(lsh_pkg::CFG_THR3, {15'd0, t3});
        cfg_we <= 1'b0;
    endtask

    // Settings of one random phase. Some phase numbers force an extreme.
    task automatic set_phase(input int ph);
        logic [16:0] thr_v [4];
        logic [16:0] swap;
        logic [2:0]  count_v;
        logic [31:0] cull_v;
        logic [19:0] tan_v;
        logic [15:0] band_v;
        if (ph == 1)
            count_v = 3'd0;
        else if (ph == 2)
            count_v = 3'd7;
        else if (ph == 3)
            count_v = 3'd1;
        else if ($urandom_range(0, 3) == 0)
            count_v = 3'($urandom_range(1, 7));
        else
            count_v = 3'd4;

        case (ph % 4)
            0: cull_v = 32'd0;
            1: cull_v = 32'hFFFF_FFFF;
            2: cull_v = $urandom;
            default: cull_v = (32'd1 << $urandom_range(12, 30)) + $urandom_range(0, 65535);
        endcase

        if (ph == 4)
            tan_v = 20'd1;
        else if (ph == 5)
            tan_v = 20'hFFFFF;
        else if (ph == 12)
            tan_v = 20'd0;
        else
            case ($urandom_range(0, 2))
                0: tan_v = 20'd65536;
                1: tan_v = 20'($urandom_range(1, 20'hFFFFF));
                default: tan_v = 20'($urandom_range(20000, 150000));
            endcase

        if (ph == 6)
            band_v = 16'd0;
        else if (ph == 7)
            band_v = 16'hFFFF;
        else
            band_v = ($urandom_range(0, 1) == 0) ? 16'd1311 : 16'($urandom_range(0, 6000));

        foreach (thr_v[i]) begin
            if (ph == 8)
                thr_v[i] = FULL_SCREEN;
            else if (ph == 11)
                thr_v[i] = 17'd0;
            else
                thr_v[i] = 17'($urandom_range(0, 65536));
        end
        // Software is meant to write descending thresholds; one phase leaves them unsorted.
        if (ph != 10)
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3 - a; b++)
                    if (thr_v[b] < thr_v[b+1]) begin
                        swap       = thr_v[b];
                        thr_v[b]   = thr_v[b+1];
                        thr_v[b+1] = swap;
                    end

        program_all(count_v, cull_v, tan_v, band_v, thr_v[0], thr_v[1], thr_v[2], thr_v[3]);
        traj_left = 0;
    endtask

    function automatic int signed_below(input int k);
        int v;
        v = int'($urandom & ((32'd1 << k) - 1));
        return ($urandom_range(0, 1) == 0) ? v : -v;
    endfunction

    // Mostly trajectories; the rest is raw noise over all bits and near-touching objects.
    function automatic query_t next_random_query();
        query_t q;
        int     pick, k, dx, dy, dz;
        real    dist_r, rad_r;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return q;
        end
        if (pick < 14) begin
            q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            q.obj_x = q.cam_x + $urandom_range(0, 80) - 40;
            q.obj_y = q.cam_y + $urandom_range(0, 80) - 40;
            q.obj_z = q.cam_z + $urandom_range(0, 80) - 40;
            return q;
        end
        if (traj_left == 0) begin
            k  = $urandom_range(2, 30);
            dx = signed_below(k);
            dy = signed_below(k);
            dz = signed_below(k);
            traj_q.cam_x = ($urandom & 32'h7FFF_FFFF) - 32'h4000_0000;
            traj_q.cam_y = ($urandom & 32'h7FFF_FFFF) - 32'h4000_0000;
            traj_q.cam_z = ($urandom & 32'h7FFF_FFFF) - 32'h4000_0000;
            traj_q.obj_x = traj_q.cam_x + dx;
            traj_q.obj_y = traj_q.cam_y + dy;
            traj_q.obj_z = traj_q.cam_z + dz;
            dist_r = $sqrt(real'(dx) * real'(dx) + real'(dy) * real'(dy)
                           + real'(dz) * real'(dz));
            // Aim the radius at a random screen share between 0 and 1.2.
            rad_r = ($urandom_range(0, 1200) / 1000.0) * dist_r
                  * (real'(levels.half_fov_tan) / 65536.0);
            if (rad_r > 4294967295.0)
                rad_r = 4294967295.0;
            traj_q.radius = 32'(longint'(rad_r));
            traj_step     = rad_r * 0.05 + 1.0;
            traj_left     = $urandom_range(8, 40);
        end
        rad_r = real'(traj_q.radius) + ($urandom_range(0, 2000) / 1000.0 - 1.0) * traj_step;
        if (rad_r < 0.0)
            rad_r = 0.0;
        else if (rad_r > 4294967295.0)
            rad_r = 4294967295.0;
        traj_q.radius = 32'(longint'(rad_r));
        traj_left--;
        return traj_q;
    endfunction

    initial begin : stimulus
        query_t q;
        int     n_items;
        levels = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // No levels set up after reset: every word comes back invalid.
        send_offset(655360, 0, 0, 32'd100000);
        q = {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_query(q);

        // Four levels, no culling, tan 1.0. At a distance of 10.0 the Q1.16 screen
        // share is exactly the radius over ten, so the radii below hit thresholds.
        drain_results();
        program_all(3'd4, 32'd0, 20'd65536, 16'd1311,
                    17'd49152, 17'd32768, 17'd16384, 17'd8192);
        send_offset(0, 0, 0, 32'd5000);             // touching
        send_offset(63, 18, 1, 32'd0);              // just under 0.001 away
        send_offset(63, 18, 2, 32'd0);              // just over, no size: last level
        send_offset(63, 18, 2, 32'hFFFF_FFFF);      // fills the screen
        q = {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_query(q);                              // farthest apart possible
        q = {32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_query(q);
        // Walk the share over the thresholds to pull the hysteresis both ways.
        send_offset(655360, 0, 0, 32'd68810);
        send_offset(655360, 0, 0, 32'd81920);
        send_offset(655360, 0, 0, 32'd163840);
        send_offset(655360, 0, 0, 32'd176950);
        send_offset(655360, 0, 0, 32'd150000);
        send_offset(655360, 0, 0, 32'd340790);
        send_offset(655360, 0, 0, 32'd327680);
        send_offset(655360, 0, 0, 32'd327670);
        send_offset(655360, 0, 0, 32'd655360);
        send_offset(655360, 0, 0, 32'd478410);

        // More levels than the block holds, culling at 10.0, and a band so wide that
        // adjusted thresholds go below zero and above one.
        drain_results();
        program_all(3'd7, 32'd655360, 20'd65536, 16'hFFFF,
                    17'd49152, 17'd32768, 17'd16384, 17'd8192);
        send_offset(655360, 0, 0, 32'd400000);      // exactly at the cull distance
        send_offset(655361, 0, 0, 32'd400000);      // just beyond it
        send_offset(0, 655359, 0, 32'd0);

        // Settle on the last of four levels, then shrink to two so that the
        // remembered level lies past the active ones.
        drain_results();
        program_all(3'd4, 32'd0, 20'd65536, 16'd0,
                    17'd49152, 17'd32768, 17'd16384, 17'd8192);
        send_offset(655360, 0, 0, 32'd0);
        drain_results();
        program_reg(lsh_pkg::CFG_LEVEL_COUNT, 32'd2);
        program_reg(lsh_pkg::CFG_HYST_BAND, 32'd1311);
        cfg_we <= 1'b0;
        send_offset(655360, 0, 0, 32'd330000);

        // Random phases, each under fresh settings.
        for (int ph = 0; ph < 14; ph++) begin
            drain_results();
            set_phase(ph);
            n_items = (ph == 1) ? 20 : 150;
            repeat (n_items) send_query(next_random_query());
        end

        drain_results();
        repeat (80) @(negedge aclk);
        if (levels.mismatches == 0 && levels.pending() == 0)
            $display("lod_select_hysteresis verification clean");
        else
            $display("lod_select_hysteresis verification failed");
        $finish;
    end

endmodule
